// ===== rtl/lrukv_pkg.sv =====
// Shared types and constants for the LRU key/value cache.
// No dependencies; lrukv_ifs.sv and lru_key_value_cache_unit.sv import this package.
package lrukv_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    typedef enum logic {
        CMD_GET = 1'b0,
        CMD_PUT = 1'b1
    } cmd_t;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

endpackage

// ===== rtl/lrukv_ifs.sv =====
// Valid/ready channel interfaces for the LRU key/value cache.
// Depends on lrukv_pkg for field widths and the command type.
interface lrukv_req_if import lrukv_pkg::*; ();
    logic                     valid;
    logic                     ready;
    cmd_t                     command;
    logic signed [DATA_W-1:0] lookup_key;
    logic signed [DATA_W-1:0] store_value;

    modport source (output valid, command, lookup_key, store_value, input ready);
    modport sink   (input valid, command, lookup_key, store_value, output ready);
endinterface

interface lrukv_rsp_if import lrukv_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;

    modport source (output valid, hit, read_value, input ready);
    modport sink   (input valid, hit, read_value, output ready);
endinterface

// ===== rtl/lrukv_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module lrukv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/lru_key_value_cache_unit.sv =====
// Top level of the fully associative LRU key/value cache.
// Depends on lrukv_pkg, lrukv_req_if / lrukv_rsp_if and lrukv_ram.
//
//  channel      dir  beat contents
//  req          in   command, lookup_key, store_value
//  rsp          out  hit, read_value (one beat per get, none per put)
//  cfg_wr_*     in   capacity, written when cfg_wr_en is high
//
// A get or put sweeps the tag RAM once to find hit / free / oldest entry,
// then a hit or any put sweeps it again to rewrite recency ranks (one entry
// a cycle through the single read port).
// A response waits in the output register while the next request is taken;
// a get holds in its response state until the previous beat is accepted.
// Reset clears valid bits, fill count and control; RAM contents are only
// ever read behind a valid bit.
module lru_key_value_cache_unit import lrukv_pkg::*; #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [CAP_W-1:0]  cfg_wr_data,
    lrukv_req_if.sink         req,
    lrukv_rsp_if.source       rsp
);

    localparam int AW     = $clog2(ENTRIES);
    localparam int RANK_W = AW;
    localparam int THR_W  = RANK_W + 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = CNT_W + CAP_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [RANK_W-1:0]   rank;
    } tag_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_UPDATE = 5'b01000,
        S_RESP   = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [CAP_W-1:0]     cap_reg;
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]     filled_reg, filled_next;

    logic [AW-1:0]        cnt_reg, cnt_next;
    logic                 iss_done_reg, iss_done_next;
    logic                 rd_vld_reg;
    logic [AW-1:0]        rd_idx_reg;

    logic                 hit_found_reg, hit_found_next;
    logic [AW-1:0]        hit_idx_reg, hit_idx_next;
    logic [RANK_W-1:0]    hit_rank_reg, hit_rank_next;
    logic                 free_found_reg, free_found_next;
    logic [AW-1:0]        free_idx_reg, free_idx_next;
    logic                 max_found_reg, max_found_next;
    logic [AW-1:0]        max_idx_reg, max_idx_next;
    logic [RANK_W-1:0]    max_rank_reg, max_rank_next;
    logic [AW-1:0]        tgt_reg, tgt_next;
    logic [THR_W-1:0]     thr_reg, thr_next;

    cmd_t                 cmd_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [DATA_W-1:0]    val_reg;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_hit_reg, out_hit_next;
    logic [DATA_W-1:0]    out_value_reg, out_value_next;
    logic                 out_load;

    logic signed [63:0]   key_ext;
    logic [KEY_BITS-1:0]  key_in;
    logic                 in_fire;

    logic                 tag_rd_en;
    tag_t                 tag_q;
    logic                 tag_wr_en;
    tag_t                 tag_wr_data;
    logic                 val_wr_en;
    logic                 val_rd_en;
    logic [DATA_W-1:0]    val_rd_data;

    logic [CMP_W-1:0]     cap_eff;
    logic                 do_fill;
    logic                 entry_valid;

    assign key_ext = 64'(req.lookup_key);
    assign key_in  = key_ext[KEY_BITS-1:0];

    assign req.ready  = (state_reg == S_IDLE);
    assign in_fire    = req.valid && req.ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.read_value = out_value_reg;

    // Capacity 0 acts as 1, above ENTRIES acts as ENTRIES
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (CMP_W'(cap_reg) > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
        else
        begin
            cap_eff = CMP_W'(cap_reg);
        end
    end

    // only a put that misses may claim a free entry
    assign do_fill = (cmd_reg == CMD_PUT) && !hit_found_reg && free_found_reg &&
                     (CMP_W'(filled_reg) < cap_eff);
    assign entry_valid = valid_reg[rd_idx_reg];

    assign tag_rd_en = ((state_reg == S_SCAN) || (state_reg == S_UPDATE)) && !iss_done_reg;

    lrukv_ram #(
        .WIDTH (KEY_BITS + RANK_W),
        .DEPTH (ENTRIES)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (tag_wr_en),
        .wr_addr (rd_idx_reg),
        .wr_data (tag_wr_data),
        .rd_en   (tag_rd_en),
        .rd_addr (cnt_reg),
        .rd_data (tag_q)
    );

    lrukv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (ENTRIES)
    ) u_val_ram (
        .clk     (clk),
        .wr_en   (val_wr_en),
        .wr_addr (tgt_next),
        .wr_data (val_reg),
        .rd_en   (val_rd_en),
        .rd_addr (hit_idx_reg),
        .rd_data (val_rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        filled_next     = filled_reg;
        cnt_next        = cnt_reg;
        iss_done_next   = iss_done_reg;
        hit_found_next  = hit_found_reg;
        hit_idx_next    = hit_idx_reg;
        hit_rank_next   = hit_rank_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        max_found_next  = max_found_reg;
        max_idx_next    = max_idx_reg;
        max_rank_next   = max_rank_reg;
        tgt_next        = tgt_reg;
        thr_next        = thr_reg;
        tag_wr_en       = 1'b0;
        tag_wr_data     = tag_q;
        val_wr_en       = 1'b0;
        val_rd_en       = 1'b0;
        out_load        = 1'b0;

        if (tag_rd_en)
        begin
            cnt_next      = cnt_reg + AW'(1);
            iss_done_next = (cnt_reg == LAST_IDX);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next        = '0;
                iss_done_next   = 1'b0;
                hit_found_next  = 1'b0;
                free_found_next = 1'b0;
                max_found_next  = 1'b0;
                if (in_fire)
                begin
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (rd_vld_reg)
                begin
                    if (entry_valid && tag_q.key == key_reg && !hit_found_reg)
                    begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = rd_idx_reg;
                        hit_rank_next  = tag_q.rank;
                    end
                    if (!entry_valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                    if (entry_valid && (!max_found_reg || tag_q.rank > max_rank_reg))
                    begin
                        max_found_next = 1'b1;
                        max_idx_next   = rd_idx_reg;
                        max_rank_next  = tag_q.rank;
                    end
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end

            S_DECIDE:
            begin
                cnt_next      = '0;
                iss_done_next = 1'b0;
                state_next    = S_UPDATE;
                if (hit_found_reg)
                begin
                    tgt_next = hit_idx_reg;
                    thr_next = THR_W'(hit_rank_reg);
                end
                else if (do_fill)
                begin
                    // new entry: every valid entry ages by one
                    tgt_next    = free_idx_reg;
                    thr_next    = THR_W'(ENTRIES);
                    valid_next[free_idx_reg] = 1'b1;
                    filled_next = filled_reg + CNT_W'(1);
                end
                else
                begin
                    tgt_next = max_idx_reg;
                    thr_next = THR_W'(max_rank_reg);
                end

                if (cmd_reg == CMD_GET)
                begin
                    val_rd_en = hit_found_reg;
                    if (!hit_found_reg)
                    begin
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    val_wr_en = hit_found_reg || do_fill || max_found_reg;
                    if (!val_wr_en)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_UPDATE:
            begin
                if (rd_vld_reg)
                begin
                    if (rd_idx_reg == tgt_reg)
                    begin
                        tag_wr_en        = 1'b1;
                        tag_wr_data.key  = key_reg;
                        tag_wr_data.rank = '0;
                    end
                    else if (entry_valid && THR_W'(tag_q.rank) < thr_reg)
                    begin
                        tag_wr_en        = 1'b1;
                        tag_wr_data.rank = tag_q.rank + RANK_W'(1);
                    end
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        state_next = (cmd_reg == CMD_GET) ? S_RESP : S_IDLE;
                    end
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        out_hit_next   = out_hit_reg;
        out_value_next = out_value_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_hit_next   = hit_found_reg;
            out_value_next = hit_found_reg ? val_rd_data : MISS_VALUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cap_reg        <= CAP_RESET;
            valid_reg      <= '0;
            filled_reg     <= '0;
            cnt_reg        <= '0;
            iss_done_reg   <= 1'b0;
            rd_vld_reg     <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            max_found_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
            valid_reg      <= valid_next;
            filled_reg     <= filled_next;
            cnt_reg        <= cnt_next;
            iss_done_reg   <= iss_done_next;
            rd_vld_reg     <= tag_rd_en;
            hit_found_reg  <= hit_found_next;
            free_found_reg <= free_found_next;
            max_found_reg  <= max_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= cnt_reg;
        hit_idx_reg   <= hit_idx_next;
        hit_rank_reg  <= hit_rank_next;
        free_idx_reg  <= free_idx_next;
        max_idx_reg   <= max_idx_next;
        max_rank_reg  <= max_rank_next;
        tgt_reg       <= tgt_next;
        thr_reg       <= thr_next;
        out_hit_reg   <= out_hit_next;
        out_value_reg <= out_value_next;
        if (in_fire)
        begin
            cmd_reg <= req.command;
            key_reg <= key_in;
            val_reg <= DATA_W'(req.store_value);
        end
    end

    a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(filled_reg))
        else $error("fill count out of step with valid bits");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(filled_reg) <= ENTRIES)
        else $error("fill count above entry count");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (!tag_wr_en && !val_wr_en))
        else $error("RAM write while idle");

    a_resp_get_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (cmd_reg == CMD_GET))
        else $error("response beat for a put");

    a_hit_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && hit_found_reg) |-> valid_reg[hit_idx_reg])
        else $error("hit on an invalid entry");

endmodule
